// ----- design/tli_pkg.sv -----
// shared constants, controller command and status types and the reset curve of the thermistor interpolator
package tli_pkg;

    // field widths of one item and one result
    localparam int CNT_W   = 12;
    localparam int TEMP_W  = 10;
    localparam int IDX_W   = 6;
    localparam int NUM_W   = 7;
    localparam int OUT_W   = 11;
    localparam int ENTRY_W = CNT_W + TEMP_W;

    // table size default and register reset
    localparam int              DEF_MAX_POINTS = 64;
    localparam logic [NUM_W-1:0] NUM_POINTS_RST = 7'd39;

    // celsius conversion: (t - 32) * 36408 >> 16
    localparam logic [15:0] C_SCALE  = 16'd36408;
    localparam int          F_OFFSET = 32;

    // divider magnitudes
    localparam int QUO_W = 22;
    localparam int DCNT_W = 5;

    // item command codes
    localparam logic CMD_WRITE   = 1'b0;
    localparam logic CMD_CONVERT = 1'b1;

    // controller to datapath commands
    typedef struct packed {
        logic take;
        logic scan;
        logic sel;
        logic mul;
        logic div;
        logic add;
        logic conv;
        logic load;
    } t_ctrl_cmd;

    // datapath to controller status
    typedef struct packed {
        logic in_valid;
        logic in_cvt;
        logic scan_done;
        logic zero;
        logic div_done;
        logic out_free;
    } t_ctrl_stat;

    // reset contents of the breakpoint table: temperature in 21..12, count in 11..0
    function automatic logic [ENTRY_W-1:0] curve_entry(input logic [7:0] idx);
        logic [ENTRY_W-1:0] e;
        case (idx)
            8'd0:    e = {10'd320, 12'd0};
            8'd1:    e = {10'd310, 12'd981};
            8'd2:    e = {10'd305, 12'd1002};
            8'd3:    e = {10'd300, 12'd1022};
            8'd4:    e = {10'd295, 12'd1055};
            8'd5:    e = {10'd290, 12'd1095};
            8'd6:    e = {10'd285, 12'd1140};
            8'd7:    e = {10'd280, 12'd1196};
            8'd8:    e = {10'd275, 12'd1250};
            8'd9:    e = {10'd270, 12'd1304};
            8'd10:   e = {10'd265, 12'd1374};
            8'd11:   e = {10'd260, 12'd1433};
            8'd12:   e = {10'd255, 12'd1491};
            8'd13:   e = {10'd250, 12'd1551};
            8'd14:   e = {10'd245, 12'd1622};
            8'd15:   e = {10'd240, 12'd1687};
            8'd16:   e = {10'd235, 12'd1765};
            8'd17:   e = {10'd230, 12'd1835};
            8'd18:   e = {10'd225, 12'd1907};
            8'd19:   e = {10'd220, 12'd1979};
            8'd20:   e = {10'd215, 12'd2055};
            8'd21:   e = {10'd210, 12'd2132};
            8'd22:   e = {10'd205, 12'd2208};
            8'd23:   e = {10'd200, 12'd2278};
            8'd24:   e = {10'd190, 12'd2437};
            8'd25:   e = {10'd180, 12'd2589};
            8'd26:   e = {10'd170, 12'd2758};
            8'd27:   e = {10'd160, 12'd2892};
            8'd28:   e = {10'd150, 12'd3025};
            8'd29:   e = {10'd140, 12'd3165};
            8'd30:   e = {10'd130, 12'd3272};
            8'd31:   e = {10'd120, 12'd3400};
            8'd32:   e = {10'd110, 12'd3469};
            8'd33:   e = {10'd100, 12'd3571};
            8'd34:   e = {10'd90,  12'd3639};
            8'd35:   e = {10'd80,  12'd3696};
            8'd36:   e = {10'd70,  12'd3758};
            8'd37:   e = {10'd60,  12'd3776};
            8'd38:   e = {10'd0,   12'd4095};
            default: e = '0;
        endcase
        return e;
    endfunction

endpackage

// ----- design/tli_intf.sv -----
// valid/ready channels of the interpolator: items in, results out, register writes

interface tli_in_if import tli_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              command;
    logic [CNT_W-1:0]  adc_count;
    logic [IDX_W-1:0]  point_index;
    logic [TEMP_W-1:0] point_temp;
    logic              want_celsius;

    modport source (output valid, command, adc_count, point_index, point_temp, want_celsius,
                    input ready);
    modport sink   (input valid, command, adc_count, point_index, point_temp, want_celsius,
                    output ready);
endinterface

interface tli_out_if import tli_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] temperature;
    logic                    out_of_range;
    logic                    zero_segment;

    modport source (output valid, temperature, out_of_range, zero_segment, input ready);
    modport sink   (input valid, temperature, out_of_range, zero_segment, output ready);
endinterface

interface tli_cfg_if import tli_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [NUM_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ----- design/tli_ram.sv -----
// generic single-write, single-read ram with registered read data
module tli_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;
endmodule

// ----- design/tli_ctrl.sv -----
// sequencing state machine of the interpolator
module tli_ctrl import tli_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_ctrl_stat i_stat,
    output t_ctrl_cmd  o_cmd
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_SEL  = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_ADD  = 3'd5;
    localparam logic [2:0] S_CONV = 3'd6;
    localparam logic [2:0] S_DONE = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.take = 1'b1;
                if (i_stat.in_valid && (i_stat.in_cvt == CMD_CONVERT)) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.scan_done) begin
                    n_state = S_SEL;
                end
            end
            S_SEL: begin
                o_cmd.sel = 1'b1;
                n_state   = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_DIV;
            end
            S_DIV: begin
                o_cmd.div = 1'b1;
                if (i_stat.zero || i_stat.div_done) begin
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                o_cmd.add = 1'b1;
                n_state   = S_CONV;
            end
            S_CONV: begin
                o_cmd.conv = 1'b1;
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

// ----- design/tli_dp.sv -----
// datapath: breakpoint store, segment scan, divider, celsius scaling, result register
module tli_dp import tli_pkg::*; #(
    parameter int MAX_POINTS = DEF_MAX_POINTS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tli_in_if.sink     i_item,
    tli_out_if.source  o_result,
    tli_cfg_if.sink    i_cfg,
    input  t_ctrl_cmd  i_cmd,
    output t_ctrl_stat o_stat
);
    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);

    // register and table storage
    logic [NUM_W-1:0]   r_num_points;
    logic [MAX_POINTS-1:0] r_valid;
    logic               wr_en;
    logic [ENTRY_W-1:0] ram_q;

    // scan state
    logic [CW-1:0]      r_n;
    logic [CW-1:0]      r_addr;
    logic               r_rdv;
    logic [AW-1:0]      r_rdi;
    logic               r_vld_d;
    logic               r_done;
    logic               r_hit;
    logic [ENTRY_W-1:0] r_prev;
    logic [ENTRY_W-1:0] r_e0;
    logic [ENTRY_W-1:0] r_e1;
    logic [CNT_W-1:0]   r_x;
    logic               r_cel;
    logic [CNT_W-1:0]   r_x1;
    logic [CNT_W-1:0]   r_x2;
    logic [TEMP_W-1:0]  r_y1;
    logic [TEMP_W-1:0]  r_y2;
    logic               r_oor;

    // arithmetic state
    logic               r_zero;
    logic               r_qneg;
    logic [CNT_W-1:0]   r_den;
    logic [CNT_W-1:0]   r_rem;
    logic [QUO_W-1:0]   r_dq;
    logic [DCNT_W-1:0]  r_dcnt;
    logic [CNT_W-1:0]   r_t;
    logic               r_dneg;
    logic [CNT_W-1:0]   r_dmag;
    logic [CNT_W+15:0]  r_cprod;

    // result register
    logic                    r_ovalid;
    logic signed [OUT_W-1:0] r_otemp;
    logic                    r_ooor;
    logic                    r_ozero;

    logic               accept;
    logic               issue;
    logic [CW-1:0]      n_eff;
    logic [ENTRY_W-1:0] cur;
    logic               hit_now;
    logic               step;
    logic               last;
    logic signed [CNT_W:0]    dxn;
    logic signed [CNT_W:0]    dx;
    logic signed [TEMP_W:0]   dy;
    logic signed [23:0]       prod;
    logic [23:0]              prod_mag;
    logic [CNT_W:0]           dx_mag;
    logic [CNT_W:0]           rem_sh;
    logic                     ge;
    logic signed [QUO_W:0]    qs;
    logic signed [QUO_W:0]    t_full;
    logic [CNT_W-1:0]         t_sel;
    logic signed [CNT_W:0]    d;
    logic [CNT_W:0]           d_mag;
    logic [CNT_W-1:0]         cq;
    logic [CNT_W-1:0]         cres;

    // handshakes
    assign i_item.ready = i_cmd.take;
    assign i_cfg.ready  = 1'b1;
    assign accept       = i_item.valid && i_cmd.take;
    assign wr_en        = accept && (i_item.command == CMD_WRITE)
                          && (32'(i_item.point_index) < MAX_POINTS);

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_points <= NUM_POINTS_RST;
        end else if (i_cfg.valid) begin
            r_num_points <= i_cfg.data;
        end
    end

    // breakpoint memory; an unwritten slot reads as the reset curve
    tli_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(MAX_POINTS)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (wr_en),
        .i_waddr(AW'(i_item.point_index)),
        .i_wdata({i_item.point_temp, i_item.adc_count}),
        .i_raddr(r_addr[AW-1:0]),
        .o_rdata(ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (wr_en) begin
            r_valid[AW'(i_item.point_index)] <= 1'b1;
        end
    end

    // points in use, clamped to the table
    always_comb begin
        if (r_num_points < 7'd2) begin
            n_eff = CW'(2);
        end else if (32'(r_num_points) > MAX_POINTS) begin
            n_eff = CW'(MAX_POINTS);
        end else begin
            n_eff = CW'(r_num_points);
        end
    end

    // scan compare on the entry just read against the one before it
    assign issue   = i_cmd.scan && (r_addr < r_n) && !r_done;
    assign cur     = r_vld_d ? ram_q : curve_entry(8'(r_rdi));
    assign step    = i_cmd.scan && r_rdv && !r_done;
    assign last    = (CW'(r_rdi) == (r_n - CW'(1)));
    assign hit_now = (r_rdi != '0) && !r_hit
                     && (r_x >= r_prev[CNT_W-1:0]) && (r_x <= cur[CNT_W-1:0]);

    // control flags of the scan
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rdv  <= 1'b0;
            r_done <= 1'b0;
            r_hit  <= 1'b0;
            r_addr <= '0;
        end else begin
            r_rdv <= issue;
            if (accept && (i_item.command == CMD_CONVERT)) begin
                r_done <= 1'b0;
                r_hit  <= 1'b0;
                r_addr <= '0;
            end else begin
                if (issue) begin
                    r_addr <= r_addr + CW'(1);
                end
                if (step) begin
                    if (hit_now) begin
                        r_hit <= 1'b1;
                    end
                    if (hit_now || last) begin
                        r_done <= 1'b1;
                    end
                end
            end
        end
    end

    // scan payload: read tags, first two entries, current segment
    always_ff @(posedge i_clk) begin
        r_rdi   <= r_addr[AW-1:0];
        r_vld_d <= r_valid[r_addr[AW-1:0]];
        if (accept && (i_item.command == CMD_CONVERT)) begin
            r_x   <= i_item.adc_count;
            r_cel <= i_item.want_celsius;
            r_n   <= n_eff;
        end
        if (step) begin
            r_prev <= cur;
            if (r_rdi == '0) begin
                r_e0 <= cur;
            end else if (!r_hit) begin
                r_x1 <= r_prev[CNT_W-1:0];
                r_y1 <= r_prev[ENTRY_W-1:CNT_W];
                r_x2 <= cur[CNT_W-1:0];
                r_y2 <= cur[ENTRY_W-1:CNT_W];
            end
            if (r_rdi == AW'(1)) begin
                r_e1 <= cur;
            end
        end
        // clamp a count outside the table to the end segment
        if (i_cmd.sel) begin
            r_oor <= !r_hit;
            if (!r_hit) begin
                if (r_x < r_e0[CNT_W-1:0]) begin
                    r_x  <= r_e0[CNT_W-1:0];
                    r_x1 <= r_e0[CNT_W-1:0];
                    r_y1 <= r_e0[ENTRY_W-1:CNT_W];
                    r_x2 <= r_e1[CNT_W-1:0];
                    r_y2 <= r_e1[ENTRY_W-1:CNT_W];
                end else begin
                    r_x <= r_x2;
                end
            end
        end
    end

    // segment slope product and divider operands
    assign dxn      = $signed({1'b0, r_x}) - $signed({1'b0, r_x1});
    assign dx       = $signed({1'b0, r_x2}) - $signed({1'b0, r_x1});
    assign dy       = $signed({1'b0, r_y2}) - $signed({1'b0, r_y1});
    assign prod     = 24'(dxn) * 24'(dy);
    assign prod_mag = prod[23] ? 24'(-prod) : 24'(prod);
    assign dx_mag   = dx[CNT_W] ? (CNT_W+1)'(-dx) : (CNT_W+1)'(dx);

    // restoring divide step, one quotient bit a cycle
    assign rem_sh = {r_rem, r_dq[QUO_W-1]};
    assign ge     = rem_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_zero <= (dx == '0);
            r_qneg <= prod[23] ^ dx[CNT_W];
            r_den  <= dx_mag[CNT_W-1:0];
            r_dq   <= prod_mag[QUO_W-1:0];
            r_rem  <= '0;
            r_dcnt <= '0;
        end else if (i_cmd.div && !r_zero) begin
            r_rem  <= ge ? CNT_W'(rem_sh - {1'b0, r_den}) : rem_sh[CNT_W-1:0];
            r_dq   <= {r_dq[QUO_W-2:0], ge};
            r_dcnt <= r_dcnt + DCNT_W'(1);
        end
    end

    // temperature from start of segment plus signed quotient
    assign qs     = r_qneg ? -$signed({1'b0, r_dq}) : $signed({1'b0, r_dq});
    assign t_full = $signed({{(QUO_W-TEMP_W){1'b0}}, r_y1}) + qs;
    assign t_sel  = r_zero ? CNT_W'(r_y1) : t_full[CNT_W-1:0];
    assign d      = $signed({t_sel[CNT_W-1], t_sel}) - (CNT_W+1)'(F_OFFSET);
    assign d_mag  = d[CNT_W] ? (CNT_W+1)'(-d) : (CNT_W+1)'(d);

    // celsius scaling, truncated toward zero
    assign cq   = r_cprod[CNT_W+15:16];
    assign cres = r_dneg ? CNT_W'(-cq) : cq;

    always_ff @(posedge i_clk) begin
        if (i_cmd.add) begin
            r_t    <= t_sel;
            r_dneg <= d[CNT_W];
            r_dmag <= d_mag[CNT_W-1:0];
        end
        if (i_cmd.conv) begin
            r_cprod <= (CNT_W+16)'(r_dmag) * (CNT_W+16)'(C_SCALE);
        end
        if (i_cmd.load) begin
            r_otemp <= r_cel ? $signed(cres[OUT_W-1:0]) : $signed(r_t[OUT_W-1:0]);
            r_ooor  <= r_oor;
            r_ozero <= r_zero;
        end
    end

    // result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.load) begin
            r_ovalid <= 1'b1;
        end else if (o_result.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    assign o_result.valid        = r_ovalid;
    assign o_result.temperature  = r_otemp;
    assign o_result.out_of_range = r_ooor;
    assign o_result.zero_segment = r_ozero;

    // status to the controller
    assign o_stat.in_valid  = i_item.valid;
    assign o_stat.in_cvt    = i_item.command;
    assign o_stat.scan_done = r_done;
    assign o_stat.zero      = r_zero;
    assign o_stat.div_done  = (r_dcnt == DCNT_W'(QUO_W - 1));
    assign o_stat.out_free  = !r_ovalid || o_result.ready;
endmodule

// ----- design/thermistor_lut_interpolator_unit.sv -----
// top level of the thermistor look-up interpolator
//
// Items arrive on i_item (valid/ready). A write item stores one breakpoint
// (count, temperature in F) in slot point_index and is taken while idle; it
// gives no result. A convert item finds the first table segment holding
// adc_count, interpolates linearly with a signed divide truncated toward zero,
// and optionally scales to Celsius. The result leaves on o_result.
// i_cfg writes the number of breakpoints in use; it is always ready.
// A convert scans up to the n points in use, one breakpoint a cycle, through the
// single read port of the table memory; then the divider makes one quotient
// bit a cycle. One item is in work at a time. Results sit in an output
// register, so the next item is taken while a result waits; a convert that
// finishes while the receiver still stalls holds until the register frees.
// Reset restores the 39-point curve (slots never written read as the curve,
// or zero past it) and sets the point count to 39; no clearing pass is needed.
module thermistor_lut_interpolator_unit import tli_pkg::*; #(
    parameter int MAX_POINTS = DEF_MAX_POINTS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tli_in_if.sink    i_item,
    tli_out_if.source o_result,
    tli_cfg_if.sink   i_cfg
);
    t_ctrl_cmd  cmd;
    t_ctrl_stat stat;

    // sequencer
    tli_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_stat (stat),
        .o_cmd  (cmd)
    );

    // datapath
    tli_dp #(
        .MAX_POINTS(MAX_POINTS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .o_result(o_result),
        .i_cfg   (i_cfg),
        .i_cmd   (cmd),
        .o_stat  (stat)
    );
endmodule

// ----- dv/tli_result_checker.sv -----
// checker for the thermistor interpolator: table and point-count tracking, result prediction and compare
module tli_result_checker import tli_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    tli_in_if    i_item,
    tli_out_if   i_result,
    tli_cfg_if   i_cfg,
    output int   o_fail_cnt,
    output int   o_pending_cnt
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH = DEF_MAX_POINTS;
    localparam int CURVE_LEN   = 39;

    // power-up thermistor curve, count and temperature in F
    localparam int CURVE_CNT [0:CURVE_LEN-1] = '{
        0, 981, 1002, 1022, 1055, 1095, 1140, 1196, 1250, 1304,
        1374, 1433, 1491, 1551, 1622, 1687, 1765, 1835, 1907, 1979,
        2055, 2132, 2208, 2278, 2437, 2589, 2758, 2892, 3025, 3165,
        3272, 3400, 3469, 3571, 3639, 3696, 3758, 3776, 4095};
    localparam int CURVE_TEMP [0:CURVE_LEN-1] = '{
        320, 310, 305, 300, 295, 290, 285, 280, 275, 270,
        265, 260, 255, 250, 245, 240, 235, 230, 225, 220,
        215, 210, 205, 200, 190, 180, 170, 160, 150, 140,
        130, 120, 110, 100, 90, 80, 70, 60, 0};

    typedef struct packed {
        logic signed [OUT_W-1:0] temperature;
        logic                    out_of_range;
        logic                    zero_segment;
    } t_reading;

    logic [ENTRY_W-1:0] bp_table [TABLE_DEPTH];
    logic [NUM_W-1:0]   points_reg;
    t_reading           pending_readings [$];
    t_reading           want;
    int                 fail_cnt;

    function automatic int count_at(input int i);
        return int'(bp_table[i][CNT_W-1:0]);
    endfunction

    function automatic int temp_at(input int i);
        return int'(bp_table[i][ENTRY_W-1:CNT_W]);
    endfunction

    // segment search, linear interpolation and optional celsius scaling
    function automatic t_reading interp_temperature(input logic [CNT_W-1:0] count,
                                                    input logic celsius);
        t_reading r;
        int       n, seg, x, x1, y1, x2, y2, dx, t, d, mag;
        bit       found;
        n     = int'(points_reg);
        if (n < 2) n = 2;
        if (n > TABLE_DEPTH) n = TABLE_DEPTH;
        x     = int'(count);
        seg   = 0;
        found = 1'b0;
        r     = '0;
        for (int k = 0; k + 1 < n; k++) begin
            if (!found && x >= count_at(k) && x <= count_at(k + 1)) begin
                seg   = k;
                found = 1'b1;
            end
        end
        // clamp to the nearest end segment
        if (!found) begin
            r.out_of_range = 1'b1;
            if (x < count_at(0)) begin
                seg = 0;
                x   = count_at(0);
            end else begin
                seg = n - 2;
                x   = count_at(n - 1);
            end
        end
        x1 = count_at(seg);
        y1 = temp_at(seg);
        x2 = count_at(seg + 1);
        y2 = temp_at(seg + 1);
        dx = x2 - x1;
        if (dx == 0) begin
            r.zero_segment = 1'b1;
            t = y1;
        end else begin
            t = y1 + ((x - x1) * (y2 - y1)) / dx;
        end
        // magnitude scaling keeps truncation toward zero
        if (celsius) begin
            d   = t - F_OFFSET;
            mag = (d < 0) ? -d : d;
            mag = (mag * int'(C_SCALE)) >> 16;
            t   = (d < 0) ? -mag : mag;
        end
        r.temperature = OUT_W'(t);
        return r;
    endfunction

    // track state and compare results at each rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < TABLE_DEPTH; k++) begin
                if (k < CURVE_LEN) begin
                    bp_table[k] = {TEMP_W'(CURVE_TEMP[k]), CNT_W'(CURVE_CNT[k])};
                end else begin
                    bp_table[k] = '0;
                end
            end
            points_reg = NUM_POINTS_RST;
            pending_readings.delete();
            fail_cnt = 0;
        end else begin
            // result side first, so a result never meets an item taken on the same edge
            if (i_result.valid && i_result.ready) begin
                if (pending_readings.size() == 0) begin
                    $error("unexpected result: temperature %0d", i_result.temperature);
                    fail_cnt++;
                end else begin
                    want = pending_readings.pop_front();
                    if (i_result.temperature !== want.temperature) begin
                        $error("temperature: expected %0d, actual %0d",
                               want.temperature, i_result.temperature);
                        fail_cnt++;
                    end
                    if (i_result.out_of_range !== want.out_of_range) begin
                        $error("out_of_range: expected %0b, actual %0b",
                               want.out_of_range, i_result.out_of_range);
                        fail_cnt++;
                    end
                    if (i_result.zero_segment !== want.zero_segment) begin
                        $error("zero_segment: expected %0b, actual %0b",
                               want.zero_segment, i_result.zero_segment);
                        fail_cnt++;
                    end
                end
            end
            // point-count register write
            if (i_cfg.valid && i_cfg.ready) begin
                points_reg = i_cfg.data;
            end
            // item: breakpoint load or conversion
            if (i_item.valid && i_item.ready) begin
                if (i_item.command == CMD_WRITE) begin
                    bp_table[i_item.point_index] = {i_item.point_temp, i_item.adc_count};
                end else begin
                    pending_readings.push_back(
                        interp_temperature(i_item.adc_count, i_item.want_celsius));
                end
            end
        end
        o_fail_cnt    <= fail_cnt;
        o_pending_cnt <= pending_readings.size();
    end

endmodule

// ----- dv/tb_thermistor_lut_interpolator_unit.sv -----
// testbench top for the thermistor interpolator: clock, reset, item and register stimulus, verdict
module tb_thermistor_lut_interpolator_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import tli_pkg::*;

    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int DRAIN_CYCLES = 120;
    localparam int PHASE_ITEMS  = 200;

    logic i_clk;
    logic i_rst_n;
    int   fail_cnt;
    int   pending_cnt;
    int   cycle_cnt = 0;
    bit   idle_on   = 1'b1;

    tli_in_if  item_if ();
    tli_out_if result_if ();
    tli_cfg_if cfg_if ();

    thermistor_lut_interpolator_unit u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_if),
        .o_result (result_if),
        .i_cfg    (cfg_if)
    );

    tli_result_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item        (item_if),
        .i_result      (result_if),
        .i_cfg         (cfg_if),
        .o_fail_cnt    (fail_cnt),
        .o_pending_cnt (pending_cnt)
    );

    // 20 ns clock
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= LIMIT_CYCLES) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // result-side stalls in random bursts
    initial begin
        result_if.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (idle_on && $urandom_range(0, 3) == 0) begin
                result_if.ready = 1'b0;
                repeat ($urandom_range(1, 14)) @(negedge i_clk);
            end
            result_if.ready = 1'b1;
            repeat ($urandom_range(1, 20)) @(negedge i_clk);
        end
    end

    // present one item and hold it until taken
    task automatic send_item(input logic cmd, input logic [CNT_W-1:0] cnt,
                             input logic [IDX_W-1:0] idx, input logic [TEMP_W-1:0] ptemp,
                             input logic celsius);
        item_if.valid        = 1'b1;
        item_if.command      = cmd;
        item_if.adc_count    = cnt;
        item_if.point_index  = idx;
        item_if.point_temp   = ptemp;
        item_if.want_celsius = celsius;
        @(posedge i_clk);
        while (!item_if.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_point(input logic [IDX_W-1:0] idx, input logic [CNT_W-1:0] cnt,
                               input logic [TEMP_W-1:0] ptemp);
        send_item(CMD_WRITE, cnt, idx, ptemp, 1'($urandom_range(0, 1)));
    endtask

    // unused fields of a conversion carry random noise
    task automatic convert(input logic [CNT_W-1:0] cnt, input logic celsius);
        send_item(CMD_CONVERT, cnt, IDX_W'($urandom_range(0, 63)),
                  TEMP_W'($urandom_range(0, 1023)), celsius);
    endtask

    // sender gap burst
    task automatic pause_sender();
        if (idle_on && $urandom_range(0, 4) == 0) begin
            item_if.valid = 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge i_clk);
        end
    endtask

    // hold off until every conversion has returned and the block has settled
    task automatic wait_idle();
        item_if.valid = 1'b0;
        while (pending_cnt != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_cfg(input logic [NUM_W-1:0] value);
        cfg_if.valid = 1'b1;
        cfg_if.data  = value;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_if.valid = 1'b0;
    endtask

    // one setting: load an ascending table, then mostly in-range conversions
    task automatic run_phase(input logic [NUM_W-1:0] cfg_val, input bit quiet);
        int n, cur, lo, hi, pick;
        wait_idle();
        write_cfg(cfg_val);
        idle_on = !quiet;
        n = (cfg_val < 2) ? 2 : (cfg_val > DEF_MAX_POINTS) ? DEF_MAX_POINTS : int'(cfg_val);
        cur = $urandom_range(0, 300);
        lo  = cur;
        hi  = cur;
        for (int k = 0; k < n; k++) begin
            pause_sender();
            write_point(k[IDX_W-1:0], cur[CNT_W-1:0], TEMP_W'($urandom_range(0, 1023)));
            hi = cur;
            // occasional repeated count gives a zero-width segment
            if ($urandom_range(0, 15) != 0) cur = cur + $urandom_range(1, 8190 / n);
            if (cur > 4095) cur = 4095;
        end
        for (int k = n; k < PHASE_ITEMS; k++) begin
            pause_sender();
            pick = $urandom_range(0, 99);
            if (pick < 80) begin
                convert(CNT_W'($urandom_range(lo, hi)), 1'($urandom_range(0, 1)));
            end else if (pick < 92) begin
                convert(CNT_W'($urandom_range(0, 4095)), 1'($urandom_range(0, 1)));
            end else begin
                write_point(IDX_W'($urandom_range(0, 63)), CNT_W'($urandom_range(0, 4095)),
                            TEMP_W'($urandom_range(0, 1023)));
            end
        end
    endtask

    // main sequence
    initial begin
        i_rst_n              = 1'b0;
        item_if.valid        = 1'b0;
        item_if.command      = CMD_WRITE;
        item_if.adc_count    = '0;
        item_if.point_index  = '0;
        item_if.point_temp   = '0;
        item_if.want_celsius = 1'b0;
        cfg_if.valid         = 1'b0;
        cfg_if.data          = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // power-up curve: ends of the count range and two inner counts, both units
        convert(12'd0, 1'b0);
        convert(12'd0, 1'b1);
        convert(12'd4095, 1'b0);
        convert(12'd4095, 1'b1);
        convert(12'd2000, 1'b0);
        convert(12'd3777, 1'b1);
        // top slot, outside the points in use
        write_point(6'd63, 12'd4095, 10'd1023);
        // count below the first breakpoint
        write_point(6'd0, 12'd100, 10'd1023);
        convert(12'd50, 1'b0);
        convert(12'd50, 1'b1);
        // count above the last breakpoint
        write_point(6'd38, 12'd3900, 10'd0);
        convert(12'd4095, 1'b0);
        // zero-width first segment
        write_point(6'd1, 12'd100, 10'd0);
        convert(12'd100, 1'b0);
        convert(12'd100, 1'b1);
        // table no longer ascending
        write_point(6'd2, 12'd0, 10'd500);
        convert(12'd50, 1'b0);
        write_point(6'd1, 12'd4095, 10'd7);
        convert(12'd4095, 1'b1);
        convert(12'd2500, 1'b0);

        // register settings, extremes and out-of-range values among them
        run_phase(7'd2, 1'b0);
        run_phase(7'd64, 1'b0);
        run_phase(7'd0, 1'b1);
        run_phase(7'd127, 1'b0);
        run_phase(NUM_W'($urandom_range(3, 63)), 1'b0);
        run_phase(7'd1, 1'b0);
        run_phase(NUM_W'($urandom_range(3, 63)), 1'b0);
        run_phase(7'd65, 1'b1);

        wait_idle();
        if (fail_cnt == 0 && pending_cnt == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ----- files.f -----
design/tli_pkg.sv
design/tli_intf.sv
design/tli_ram.sv
design/tli_ctrl.sv
design/tli_dp.sv
design/thermistor_lut_interpolator_unit.sv
dv/tli_result_checker.sv
dv/tb_thermistor_lut_interpolator_unit.sv
